[hdl/srb_pkg.sv]
`default_nettype none

package srb_pkg;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] packet_id;
    logic [15:0] packet_size;
    logic [31:0] packet_handle;
  } in_pkt_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [31:0] out_id;
    logic [15:0] out_size;
    logic [31:0] total_bytes;
    logic [6:0]  held_count;
    logic        next_ready;
  } out_pkt_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] size;
    logic [31:0] handle;
  } slot_t;

  // one-hot in practice: at most one load source per cell
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/srb_cell.sv]
`default_nettype none

module srb_cell
  import srb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cmp_en_i,
  input  wire         occ_i,
  input  wire  [31:0] cmp_id_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire slot_t  new_i,
  input  wire slot_t  left_i,
  input  wire slot_t  right_i,
  output slot_t       slot_o,
  output logic        gt_o,
  output logic        eq_o
);

  slot_t slot_q;
  logic  gt_q;
  logic  eq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_new) begin
      slot_q <= new_i;
    end else if (ctrl_i.take_left) begin
      slot_q <= left_i;
    end else if (ctrl_i.take_right) begin
      slot_q <= right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmp_en_i) begin
      gt_q <= occ_i && (slot_q.id > cmp_id_i);
      eq_q <= occ_i && (slot_q.id == cmp_id_i);
    end
  end

  assign slot_o = slot_q;
  assign gt_o   = gt_q;
  assign eq_o   = eq_q;

endmodule

`default_nettype wire

[hdl/sequence_reorder_buffer_top.sv]
// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_stall_o    | in_pkt_i  (in_pkt_t)
// out     | output    | out_valid_o / out_stall_i  | out_pkt_o (out_pkt_t)
// cfg     | input     | cfg_we_i, no back-pressure | cfg_wdata_i (start_id)
//
// Per item: the accept edge registers the id compares in every cell of the
// chain, and the execute edge shifts the chain for a push or pop and loads the result.
// The execute edge waits while an earlier result is still stalled.
// in_stall_o is high from accept until the execute edge.
// Reset clears count, expected id and byte total; slot contents are not reset.
`default_nettype none

module sequence_reorder_buffer_top
  import srb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire in_pkt_t in_pkt_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output out_pkt_t    out_pkt_o,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i
);

  localparam int CntW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] held_q, held_d;
  logic [31:0]     expected_q, expected_d;
  logic [31:0]     total_q, total_d;
  in_pkt_t         req_q;
  logic            eq0_q, eq1_q, eqn_q;
  logic            out_valid_q;
  out_pkt_t        out_q, out_d;

  slot_t           slots [DEPTH];
  cell_ctrl_t      ctrl  [DEPTH];
  logic [DEPTH-1:0] gt_vec, eq_vec, occ_vec;

  logic accept, exec_go, full, dup, push_ok, pop_ok, pos0;
  slot_t new_slot;

  assign accept  = in_valid_i && !in_stall_o;
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_pkt_o   = out_q;

  assign new_slot.id     = req_q.packet_id;
  assign new_slot.size   = req_q.packet_size;
  assign new_slot.handle = req_q.packet_handle;

  assign full    = (held_q == CntW'(DEPTH));
  assign dup     = |eq_vec;
  assign push_ok = exec_go && (req_q.mode == MODE_PUSH) && !full && !dup;
  assign pop_ok  = exec_go && (req_q.mode == MODE_POP) && (held_q != '0) && eq0_q;
  assign pos0    = gt_vec[0] || (held_q == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    logic left_gt;

    assign occ_vec[i] = (CntW'(i) < held_q);

    if (i == 0) begin : g_first
      assign left_gt = 1'b0;
    end else begin : g_rest
      assign left_gt = gt_vec[i-1];
    end

    assign ctrl[i].take_left  = push_ok && left_gt;
    assign ctrl[i].take_new   = push_ok && !left_gt && (gt_vec[i] || !occ_vec[i]);
    assign ctrl[i].take_right = pop_ok && (i < DEPTH - 1);

    srb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmp_en_i (accept),
      .occ_i    (occ_vec[i]),
      .cmp_id_i (in_pkt_i.packet_id),
      .ctrl_i   (ctrl[i]),
      .new_i    (new_slot),
      .left_i   (slots[(i == 0) ? 0 : i - 1]),
      .right_i  (slots[(i == DEPTH - 1) ? i : i + 1]),
      .slot_o   (slots[i]),
      .gt_o     (gt_vec[i]),
      .eq_o     (eq_vec[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    expected_d = expected_q;
    total_d    = total_q;
    out_d      = out_q;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (cfg_we_i) begin
      expected_d = cfg_wdata_i;
    end

    if (exec_go) begin
      state_d          = S_IDLE;
      out_d.status     = ST_OK;
      out_d.out_handle = '0;
      out_d.out_id     = '0;
      out_d.out_size   = '0;
      out_d.next_ready = (held_q != '0) && eq0_q;
      case (req_q.mode)
        MODE_PUSH: begin
          if (full) begin
            out_d.status = ST_FULL;
          end else if (dup) begin
            out_d.status = ST_DUP;
          end else begin
            held_d           = held_q + 1'b1;
            total_d          = total_q + 32'(req_q.packet_size);
            out_d.next_ready = pos0 ? eqn_q : eq0_q;
          end
        end
        MODE_POP: begin
          if (pop_ok) begin
            held_d           = held_q - 1'b1;
            expected_d       = expected_q + 32'd1;
            total_d          = total_q - 32'(slots[0].size);
            out_d.out_handle = slots[0].handle;
            out_d.out_id     = slots[0].id;
            out_d.out_size   = slots[0].size;
            out_d.next_ready = (held_q > CntW'(1)) && eq1_q;
          end else begin
            out_d.status = ST_NOT_READY;
          end
        end
        MODE_CLEAR: begin
          held_d           = '0;
          total_d          = '0;
          out_d.next_ready = 1'b0;
        end
        default: begin
        end
      endcase
      out_d.total_bytes = total_d;
      out_d.held_count  = 7'(held_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      expected_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      held_q     <= held_d;
      expected_q <= expected_d;
      total_q    <= total_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      req_q <= in_pkt_i;
      eq0_q <= (slots[0].id == expected_q);
      eq1_q <= (slots[1].id == (expected_q + 32'd1));
      eqn_q <= (in_pkt_i.packet_id == expected_q);
    end
  end

`ifndef SYNTHESIS
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(DEPTH))
    else $error("held count beyond store depth");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (total_q == '0))
    else $error("byte total nonzero with empty store");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |-> (out_q.out_id == '0 && out_q.out_size == '0))
    else $error("released fields on failed step");
`endif

endmodule

`default_nettype wire
